### rtl/tks_pkg.sv
`timescale 1ns / 1ps

package tks_pkg;

    localparam int KEY_W           = 32;
    localparam int IDX_W           = 10;
    localparam int LEN_W           = 11;
    localparam int CFG_IDX_W       = 8;
    localparam int CFG_DATA_W      = 16;
    localparam int DEF_TABLE_DEPTH = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE  = CFG_IDX_W'(1);

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;
    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_BINARY = 1'b1;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [IDX_W-1:0] position;
    } t_result;

endpackage

### rtl/tks_key_ram.sv
`timescale 1ns / 1ps

module tks_key_ram
    import tks_pkg::*;
#(
    parameter int DEPTH = DEF_TABLE_DEPTH,
    parameter int AW    = $clog2(DEF_TABLE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_key          i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_key          o_rd_data
);

    t_key r_mem [DEPTH];
    t_key r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/tks_search.sv
`timescale 1ns / 1ps

module tks_search
    import tks_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int AW          = $clog2(DEF_TABLE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg_wr          i_cfg,
    input  logic             i_start,
    input  logic             i_kind,
    input  logic [IDX_W-1:0] i_entry_index,
    input  t_key             i_key_value,
    output logic             o_busy,
    output t_result          o_result,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output t_key             o_wr_data,
    output logic             o_rd_en,
    output logic [AW-1:0]    o_rd_addr,
    input  t_key             i_rd_data
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int WW = (CW > LEN_W) ? CW : LEN_W;
    localparam int SW = WW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMPR
    } t_state;

    t_state                r_state,  n_state;
    logic [LEN_W-1:0]      r_table_length, n_table_length;
    logic                  r_search_mode,  n_search_mode;
    logic                  r_mode,   n_mode;
    logic [WW-1:0]         r_len,    n_len;
    t_key                  r_key,    n_key;
    logic signed [SW-1:0]  r_lo,     n_lo;
    logic signed [SW-1:0]  r_hi,     n_hi;
    logic [WW-1:0]         r_idx,    n_idx;
    logic [AW-1:0]         r_addr,   n_addr;
    logic                  r_done,   n_done;
    logic                  r_found,  n_found;
    logic [IDX_W-1:0]      r_pos,    n_pos;

    logic [WW-1:0]         len_ext;
    logic [WW-1:0]         wr_idx_ext;
    logic signed [SW-1:0]  mid_w;
    logic signed [SW-1:0]  addr_s;
    logic [WW-1:0]         addr_ext;
    logic                  window_empty;
    logic                  accept;

    assign accept     = i_start && (r_state == S_IDLE);
    assign len_ext    = WW'(r_table_length);
    assign wr_idx_ext = WW'(i_entry_index);
    assign mid_w      = (r_lo + r_hi) >>> 1;
    assign addr_s     = SW'($unsigned(r_addr));
    assign addr_ext   = WW'(r_addr);

    always_comb begin
        if (r_mode == MODE_BINARY) begin
            window_empty = (r_lo > r_hi);
        end else begin
            window_empty = (r_idx >= r_len);
        end
    end

    assign o_wr_en   = accept && (i_kind == KIND_WRITE) && (wr_idx_ext < WW'(TABLE_DEPTH));
    assign o_wr_addr = wr_idx_ext[AW-1:0];
    assign o_wr_data = i_key_value;
    assign o_rd_en   = (r_state == S_PROBE) && !window_empty;
    assign o_rd_addr = (r_mode == MODE_BINARY) ? mid_w[AW-1:0] : r_idx[AW-1:0];

    always_comb begin
        n_state        = r_state;
        n_table_length = r_table_length;
        n_search_mode  = r_search_mode;
        n_mode         = r_mode;
        n_len          = r_len;
        n_key          = r_key;
        n_lo           = r_lo;
        n_hi           = r_hi;
        n_idx          = r_idx;
        n_addr         = r_addr;
        n_done         = 1'b0;
        n_found        = r_found;
        n_pos          = r_pos;

        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TABLE_LENGTH: n_table_length = i_cfg.data[LEN_W-1:0];
                CFG_SEARCH_MODE:  n_search_mode  = i_cfg.data[0];
                default:          ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (accept && (i_kind == KIND_QUERY)) begin
                    n_state = S_PROBE;
                    n_mode  = r_search_mode;
                    n_key   = i_key_value;
                    n_idx   = '0;
                    n_lo    = '0;
                    if (len_ext > WW'(TABLE_DEPTH)) begin
                        n_len = WW'(TABLE_DEPTH);
                        n_hi  = SW'(TABLE_DEPTH) - SW'(1);
                    end else begin
                        n_len = len_ext;
                        n_hi  = SW'($unsigned(len_ext)) - SW'(1);
                    end
                end
            end
            S_PROBE: begin
                if (window_empty) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    n_found = 1'b0;
                    n_pos   = '0;
                end else begin
                    n_state = S_CMPR;
                    n_addr  = o_rd_addr;
                end
            end
            S_CMPR: begin
                if (i_rd_data == r_key) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    n_found = 1'b1;
                    n_pos   = addr_ext[IDX_W-1:0];
                end else begin
                    n_state = S_PROBE;
                    if (r_mode == MODE_LINEAR) begin
                        n_idx = r_idx + WW'(1);
                    end else if (i_rd_data > r_key) begin
                        n_hi = addr_s - SW'(1);
                    end else begin
                        n_lo = addr_s + SW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_table_length <= '0;
            r_search_mode  <= MODE_BINARY;
            r_done         <= 1'b0;
            r_lo           <= '0;
            r_hi           <= '0;
        end else begin
            r_state        <= n_state;
            r_table_length <= n_table_length;
            r_search_mode  <= n_search_mode;
            r_done         <= n_done;
            r_lo           <= n_lo;
            r_hi           <= n_hi;
        end
        r_mode  <= n_mode;
        r_len   <= n_len;
        r_key   <= n_key;
        r_idx   <= n_idx;
        r_addr  <= n_addr;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_result.done     = r_done;
    assign o_result.found    = r_found;
    assign o_result.position = r_pos;

endmodule

### rtl/table_key_search.sv
`timescale 1ns / 1ps

// Keeps a table of signed 32-bit keys in a single-port-read synchronous memory and answers
// queries with a found flag and a position, which appear for exactly one cycle with o_done
// because the receiver cannot stall. A write request (kind 0) gives no result and leaves
// o_busy low. A query raises o_busy; every memory probe puts out an address in S_PROBE and
// then compares the registered read data in S_CMPR, since there is one read port, so a
// binary query halves its window at each probe and a linear query steps through the
// entries in order. The result is shown in the same cycle that o_busy falls, and a new
// request may be taken in that same cycle. Entries never written read as arbitrary data,
// and no clearing pass runs after reset.
module table_key_search
    import tks_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_kind,
    input  logic [IDX_W-1:0]      i_entry_index,
    input  logic signed [KEY_W-1:0] i_key_value,
    output logic                  o_done,
    output logic                  o_found,
    output logic [IDX_W-1:0]      o_position,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    t_cfg_wr       cfg;
    t_result       result;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_key          wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_key          rd_data;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    tks_search #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_search (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_start       (i_start),
        .i_kind        (i_kind),
        .i_entry_index (i_entry_index),
        .i_key_value   (i_key_value),
        .o_busy        (o_busy),
        .o_result      (result),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data)
    );

    tks_key_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_done     = result.done;
    assign o_found    = result.found;
    assign o_position = result.position;

endmodule

### rtl/tks_checker.sv
`timescale 1ns / 1ps

module tks_checker
    import tks_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_start,
    input logic             o_busy,
    input logic             i_kind,
    input logic             o_done,
    input logic             o_found,
    input logic [IDX_W-1:0] o_position
);

    // A result only ever follows a query that held the block busy.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("result strobe without a preceding busy query");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_miss_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (o_position == '0))
        else $error("position not zero on a miss");

    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_kind == KIND_WRITE)) |=> !o_busy)
        else $error("write request made the block busy");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_kind == KIND_QUERY)) |=> (o_busy && !o_done))
        else $error("query request did not start a search");

endmodule

bind table_key_search tks_checker u_tks_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (i_start),
    .o_busy     (o_busy),
    .i_kind     (i_kind),
    .o_done     (o_done),
    .o_found    (o_found),
    .o_position (o_position)
);

### tb/table_key_search_tb.sv
`timescale 1ns / 1ps

module table_key_search_tb;
    import tks_pkg::*;

    localparam int   STALL_LIMIT = 20000;
    localparam t_key KEY_MIN     = 32'sh8000_0000;
    localparam t_key KEY_MAX     = 32'sh7fff_ffff;

    typedef struct {
        logic             found;
        logic [IDX_W-1:0] position;
    } t_lookup_result;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_start       = 1'b0;
    logic                  i_kind        = KIND_WRITE;
    logic [IDX_W-1:0]      i_entry_index = '0;
    t_key                  i_key_value   = '0;
    logic                  i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_TABLE_LENGTH;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  o_busy;
    logic                  o_done;
    logic                  o_found;
    logic [IDX_W-1:0]      o_position;
    logic                  o_cfg_ready;

    t_key                  key_store [DEF_TABLE_DEPTH];
    logic [LEN_W-1:0]      cfg_length = '0;
    logic                  cfg_mode   = MODE_BINARY;
    logic [LEN_W-1:0]      low_bound  = '0;
    logic [LEN_W-1:0]      high_bound = '0;
    t_lookup_result        pending_lookups [$];
    t_lookup_result        due_lookup;
    int                    error_count = 0;
    int                    idle_pct    = 0;

    table_key_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_kind        (i_kind),
        .i_entry_index (i_entry_index),
        .i_key_value   (i_key_value),
        .o_done        (o_done),
        .o_found       (o_found),
        .o_position    (o_position),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int searched_span();
        return (cfg_length > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : int'(cfg_length);
    endfunction

    function automatic t_lookup_result search_table(t_key key);
        t_lookup_result res;
        int             span;
        int             lo;
        int             hi;
        int             mid;
        res.found    = 1'b0;
        res.position = '0;
        span         = searched_span();
        if (cfg_mode == MODE_LINEAR) begin
            for (int i = 0; i < span; i++) begin
                if (key_store[i] == key) begin
                    res.found    = 1'b1;
                    res.position = IDX_W'(i);
                    break;
                end
            end
        end else begin
            lo = 0;
            hi = span - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (key_store[mid] > key) begin
                    hi = mid - 1;
                end else if (key_store[mid] < key) begin
                    lo = mid + 1;
                end else begin
                    res.found    = 1'b1;
                    res.position = IDX_W'(mid);
                    break;
                end
            end
            low_bound  = LEN_W'(lo);
            high_bound = LEN_W'(hi);
        end
        return res;
    endfunction

    // The start line is left high on return so that a following request can go out at once.
    task automatic send_request(logic kind, logic [IDX_W-1:0] index, t_key key);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        i_start       <= 1'b1;
        i_kind        <= kind;
        i_entry_index <= index;
        i_key_value   <= key;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        if (kind == KIND_WRITE) begin
            key_store[index] = key;
        end else begin
            pending_lookups = {pending_lookups, search_table(key)};
        end
    endtask

    task automatic send_query(t_key key);
        send_request(KIND_QUERY, IDX_W'($urandom), key);
    endtask

    task automatic wait_until_idle();
        i_start <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic set_config(logic [LEN_W-1:0] length, logic mode);
        wait_until_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_TABLE_LENGTH;
        i_cfg_data  <= CFG_DATA_W'(length);
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        cfg_length  = length;
        i_cfg_index <= CFG_SEARCH_MODE;
        i_cfg_data  <= CFG_DATA_W'(mode);
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        cfg_mode    = mode;
        i_cfg_valid <= 1'b0;
    endtask

    // Sorted tables place one key in each of count equal buckets, so keys strictly ascend.
    task automatic load_table(int count, bit sorted, bit widest);
        longint span_all;
        longint bucket;
        longint slack;
        longint base;
        longint offset;
        t_key   key;
        span_all = longint'(1) << 32;
        if (count == 0) return;
        case ($urandom_range(0, 3))
            0: bucket = 2;
            1: bucket = 16;
            2: bucket = 65536;
            default: bucket = span_all / count;
        endcase
        if (widest || bucket * count > span_all) begin
            bucket = span_all / count;
        end
        slack = span_all - bucket * count;
        base  = -(span_all / 2) + (longint'($urandom) % (slack + 1));
        for (int i = 0; i < count; i++) begin
            if (sorted) begin
                offset = longint'($urandom) % bucket;
                key    = t_key'(base + i * bucket + offset);
            end else if ($urandom_range(0, 1) == 1) begin
                key = t_key'($urandom);
            end else begin
                key = t_key'($urandom_range(0, 6)) - t_key'(3);
            end
            send_request(KIND_WRITE, IDX_W'(i), key);
        end
    endtask

    function automatic t_key pick_key();
        int span;
        int slot;
        span = searched_span();
        slot = (span > 0) ? $urandom_range(0, span - 1) : 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return (span > 0) ? key_store[slot] : t_key'($urandom);
            5: return key_store[slot] + t_key'(1);
            6: return key_store[slot] - t_key'(1);
            7: return t_key'($urandom);
            8: return ($urandom_range(0, 1) == 1) ? KEY_MAX : KEY_MIN;
            default: return t_key'($urandom_range(0, 6)) - t_key'(3);
        endcase
    endfunction

    task automatic run_queries(int count, int noise_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_request(KIND_WRITE, IDX_W'($urandom), t_key'($urandom));
            end else begin
                send_query(pick_key());
            end
        end
    endtask

    task automatic test_directed_cases();
        idle_pct = 0;
        send_query(t_key'(0));
        set_config(LEN_W'(0), MODE_LINEAR);
        send_query(t_key'(0));
        send_request(KIND_WRITE, IDX_W'(0), KEY_MIN);
        send_request(KIND_WRITE, IDX_W'(1), t_key'(-1));
        send_request(KIND_WRITE, IDX_W'(2), t_key'(0));
        send_request(KIND_WRITE, IDX_W'(3), t_key'(1));
        send_request(KIND_WRITE, IDX_W'(4), KEY_MAX);
        send_request(KIND_WRITE, IDX_W'(1023), t_key'(32'sh5a5a_5a5a));
        set_config(LEN_W'(5), MODE_BINARY);
        send_query(KEY_MIN);
        send_query(KEY_MAX);
        send_query(t_key'(0));
        send_query(t_key'(5));
        send_query(t_key'(-2));
        set_config(LEN_W'(5), MODE_LINEAR);
        send_query(t_key'(1));
        send_query(KEY_MAX);
        send_query(t_key'(7));
        // A duplicate key after the maximum: linear finds the first copy, binary is unsorted.
        send_request(KIND_WRITE, IDX_W'(5), t_key'(-1));
        set_config(LEN_W'(6), MODE_LINEAR);
        send_query(t_key'(-1));
        set_config(LEN_W'(6), MODE_BINARY);
        send_query(t_key'(-1));
        send_query(KEY_MAX);
        set_config(LEN_W'(1), MODE_BINARY);
        send_query(KEY_MIN);
    endtask

    task automatic test_full_table();
        idle_pct = 0;
        load_table(DEF_TABLE_DEPTH, 1'b1, 1'b1);
        send_request(KIND_WRITE, IDX_W'(0), KEY_MIN);
        send_request(KIND_WRITE, IDX_W'(DEF_TABLE_DEPTH - 1), KEY_MAX);
        set_config(LEN_W'(DEF_TABLE_DEPTH), MODE_BINARY);
        send_query(KEY_MIN);
        send_query(KEY_MAX);
        run_queries(24, 0);
        set_config(LEN_W'(DEF_TABLE_DEPTH), MODE_LINEAR);
        run_queries(8, 0);
        set_config(LEN_W'(2047), MODE_BINARY);
        run_queries(8, 0);
        set_config(LEN_W'(2047), MODE_LINEAR);
        run_queries(4, 0);
    endtask

    task automatic test_random_traffic(int sender_idle, int rounds);
        int  pick;
        int  length;
        bit  sorted;
        idle_pct = sender_idle;
        for (int r = 0; r < rounds; r++) begin
            pick   = $urandom_range(0, 99);
            length = (pick < 5)  ? 0 :
                     (pick < 12) ? $urandom_range(64, 256) : $urandom_range(1, 16);
            sorted = ($urandom_range(0, 9) != 0);
            load_table(length, sorted, 1'b0);
            set_config(LEN_W'(length), logic'($urandom_range(0, 1)));
            run_queries($urandom_range(8, 16), 8);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_lookups.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual found %0b position %0d",
                         $time, o_found, o_position);
                error_count++;
            end else begin
                due_lookup = pending_lookups.pop_front();
                if (o_found !== due_lookup.found) begin
                    $display("%0t: found mismatch, expected %0b, actual %0b",
                             $time, due_lookup.found, o_found);
                    error_count++;
                end
                if (o_position !== due_lookup.position) begin
                    $display("%0t: position mismatch, expected %0d, actual %0d",
                             $time, due_lookup.position, o_position);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_full_table();
        test_random_traffic(0, 12);
        test_random_traffic(50, 12);
        test_random_traffic(19, 12);
        wait_until_idle();
        repeat (40) @(posedge i_clk);
        if (error_count == 0 && pending_lookups.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
